>>> rtl/core/mission_waypoint_rtl_sequencer_macros.svh
// Assertion macros used by the checker file of the waypoint sequencer.
`ifndef MISSION_WAYPOINT_RTL_SEQUENCER_MACROS_SVH
`define MISSION_WAYPOINT_RTL_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define MWRS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("waypoint sequencer check failed");

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define MWRS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("waypoint sequencer check failed");

`endif

>>> rtl/core/mwrs_pkg.sv
// Types and fixed constants of the mission waypoint sequencer.
package mwrs_pkg;

	localparam int POS_W = 25;
	localparam int YAW_W = 15;

	// Input item codes.
	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	// Navigation modes reported with a tick.
	localparam logic [1:0] NAV_MISSION = 2'd1;
	localparam logic [1:0] NAV_RETURN  = 2'd2;

	// Mode requests in the result.
	localparam logic [1:0] REQ_NONE   = 2'd0;
	localparam logic [1:0] REQ_RETURN = 2'd1;
	localparam logic [1:0] REQ_LAND   = 2'd2;

	// Return stages.
	localparam logic [1:0] STAGE_IDLE  = 2'd0;
	localparam logic [1:0] STAGE_CLIMB = 2'd1;
	localparam logic [1:0] STAGE_HOME  = 2'd2;
	localparam logic [1:0] STAGE_LAND  = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RET_ALT = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [31:0] RADIUS_SQ_RST = 32'd65536;
	localparam logic signed [POS_W-1:0] RET_ALT_RST = -25'sd512;

	// Climb done when the height error is below 0.2 m: err * 5 < 256.
	localparam logic [POS_W:0] CLIMB_LIMIT = 26'd52;
	// Home reached when dx^2 + dy^2 is below (0.8 m)^2: sum * 25 < 2^20.
	localparam logic [51:0] HOME_LIMIT = 52'd41944;

	// One stored waypoint.
	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic signed [YAW_W-1:0] yaw;
	} waypoint_t;

endpackage

>>> rtl/core/mission_waypoint_rtl_sequencer.sv
// Mission waypoint table walker with return-to-home sequencing.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, mode .. heading         | input
//  out     | out_valid/out_ready, setpoint_valid .. ok  | output
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data   | input
//
// A position tick reads the waypoint memory when it is accepted, then passes
// through the read state and the squaring steps, in which the squared x and y
// differences (and z on a mission) go through one shared 26 by 26 multiplier
// with an accumulate stage, and ends in the decision state. Appends, clears and
// ignored ticks go from acceptance straight to the decision state. One item is in
// work at a time; the output register lets the next item be accepted while a
// result waits. Reset is asynchronous; the waypoint memory needs no clearing.
module mission_waypoint_rtl_sequencer
	import mwrs_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              mode,
	input  logic                    pos_valid,
	input  logic                    armed,
	input  logic [1:0]              nav_mode,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic signed [YAW_W-1:0] heading,

	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    setpoint_valid,
	output logic signed [POS_W-1:0] sp_x,
	output logic signed [POS_W-1:0] sp_y,
	output logic signed [POS_W-1:0] sp_z,
	output logic signed [YAW_W-1:0] sp_yaw,
	output logic [1:0]              mode_request,
	output logic [4:0]              current_index,
	output logic [1:0]              return_stage,
	output logic                    append_ok,

	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [POS_W-1:0]        cfg_data
);

	localparam int IW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IW-1:0] DEPTH_C = IW'(TABLE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		K_REPORT,
		K_APPEND,
		K_TICK
	} kind_t;

	state_t                  state_q;
	kind_t                   kind_q;
	logic [1:0]              step_q;

	// Persistent sequencer state.
	logic [IW-1:0]           entry_q;
	logic [IW-1:0]           active_q;
	logic signed [POS_W-1:0] home_n_q;
	logic signed [POS_W-1:0] home_e_q;
	logic signed [POS_W-1:0] home_d_q;
	logic                    home_known_q;
	logic                    armed_before_q;
	logic [1:0]              stage_q;
	logic [31:0]             radius_sq_q;
	logic signed [POS_W-1:0] ret_alt_q;

	// Captured item.
	logic [1:0]              nav_q;
	logic                    app_q;
	logic signed [POS_W-1:0] px_q;
	logic signed [POS_W-1:0] py_q;
	logic signed [POS_W-1:0] pz_q;
	logic signed [YAW_W-1:0] hd_q;

	// Waypoint memory and its read register.
	waypoint_t               wp_mem [TABLE_DEPTH];
	waypoint_t               rd_s1;
	logic                    mem_we;
	logic [AW-1:0]           rd_addr;

	// Distance datapath.
	logic signed [POS_W-1:0] a_sel;
	logic signed [POS_W-1:0] b_sel;
	logic signed [POS_W:0]   d_sel;
	logic signed [51:0]      sq_prod;
	logic [50:0]             sq_s1;
	logic [51:0]             acc_q;

	// Result of the decision cycle.
	logic                    in_acc;
	logic                    out_load;
	logic signed [POS_W-1:0] home_x;
	logic signed [POS_W-1:0] home_y;
	logic signed [POS_W-1:0] tz;
	logic signed [POS_W:0]   climb_err;
	logic                    r_spv;
	logic signed [POS_W-1:0] r_x;
	logic signed [POS_W-1:0] r_y;
	logic signed [POS_W-1:0] r_z;
	logic signed [YAW_W-1:0] r_yaw;
	logic [1:0]              r_req;
	logic [IW-1:0]           active_nx;
	logic [1:0]              stage_nx;
	logic [IW+4:0]           idx_wide;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (state_q == ST_FINISH) && (!out_valid || out_ready);

	// An append is stored while the table has room.
	assign mem_we  = in_acc && (mode == MODE_APPEND) && (entry_q < DEPTH_C);
	// A disarmed tick walks from the first entry.
	assign rd_addr = armed ? active_q[AW-1:0] : '0;

	// Waypoint memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			wp_mem[entry_q[AW-1:0]] <= '{x: pos_x, y: pos_y, z: pos_z, yaw: heading};
		end
		if (in_acc) begin
			rd_s1 <= wp_mem[rd_addr];
		end
	end

	// Home falls back to the origin until it has been saved.
	assign home_x = home_known_q ? home_n_q : '0;
	assign home_y = home_known_q ? home_e_q : '0;

	// Operand selection for the shared squaring unit.
	always_comb begin
		a_sel = '0;
		b_sel = '0;
		if (nav_q == NAV_MISSION) begin
			case (step_q)
				2'd0: begin
					a_sel = rd_s1.x;
					b_sel = px_q;
				end
				2'd1: begin
					a_sel = rd_s1.y;
					b_sel = py_q;
				end
				2'd2: begin
					a_sel = rd_s1.z;
					b_sel = pz_q;
				end
				default: begin
					a_sel = '0;
					b_sel = '0;
				end
			endcase
		end else begin
			case (step_q)
				2'd0: begin
					a_sel = home_x;
					b_sel = px_q;
				end
				2'd1: begin
					a_sel = home_y;
					b_sel = py_q;
				end
				default: begin
					a_sel = '0;
					b_sel = '0;
				end
			endcase
		end
	end

	assign d_sel   = {a_sel[POS_W-1], a_sel} - {b_sel[POS_W-1], b_sel};
	assign sq_prod = d_sel * d_sel;

	// Climb target is the higher of the current height and the return height.
	assign tz        = (pz_q < ret_alt_q) ? pz_q : ret_alt_q;
	assign climb_err = {pz_q[POS_W-1], pz_q} - {tz[POS_W-1], tz};

	// Decision for the item in the finishing cycle.
	always_comb begin
		r_spv     = 1'b0;
		r_x       = '0;
		r_y       = '0;
		r_z       = '0;
		r_yaw     = '0;
		r_req     = REQ_NONE;
		active_nx = active_q;
		stage_nx  = stage_q;
		if (kind_q == K_TICK) begin
			unique case (nav_q)
				NAV_MISSION: begin
					if (active_q >= entry_q) begin
						r_req = REQ_RETURN;
					end else begin
						r_spv = 1'b1;
						r_x   = rd_s1.x;
						r_y   = rd_s1.y;
						r_z   = rd_s1.z;
						r_yaw = rd_s1.yaw;
						if (acc_q < {20'd0, radius_sq_q}) begin
							active_nx = active_q + 1'b1;
						end
					end
				end
				NAV_RETURN: begin
					unique case (stage_q)
						STAGE_IDLE: stage_nx = STAGE_CLIMB;
						STAGE_CLIMB: begin
							r_spv = 1'b1;
							r_x   = px_q;
							r_y   = py_q;
							r_z   = tz;
							r_yaw = hd_q;
							if ($unsigned(climb_err) < CLIMB_LIMIT) begin
								stage_nx = STAGE_HOME;
							end
						end
						STAGE_HOME: begin
							r_spv = 1'b1;
							r_x   = home_x;
							r_y   = home_y;
							r_z   = ret_alt_q;
							if (acc_q < HOME_LIMIT) begin
								stage_nx = STAGE_LAND;
							end
						end
						default: r_req = REQ_LAND;
					endcase
				end
				default: stage_nx = STAGE_IDLE;
			endcase
		end
	end

	assign idx_wide = {5'd0, active_nx};

	// Payload capture and the squaring pipeline register.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			nav_q <= nav_mode;
			px_q  <= pos_x;
			py_q  <= pos_y;
			pz_q  <= pos_z;
			hd_q  <= heading;
		end
		if (state_q == ST_SQUARE) begin
			sq_s1 <= sq_prod[50:0];
		end
	end

	// Sequencer state, persistent state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			kind_q         <= K_REPORT;
			step_q         <= '0;
			app_q          <= 1'b0;
			acc_q          <= '0;
			entry_q        <= '0;
			active_q       <= '0;
			home_n_q       <= '0;
			home_e_q       <= '0;
			home_d_q       <= '0;
			home_known_q   <= 1'b0;
			armed_before_q <= 1'b0;
			stage_q        <= STAGE_IDLE;
			radius_sq_q    <= RADIUS_SQ_RST;
			ret_alt_q      <= RET_ALT_RST;
			out_valid      <= 1'b0;
			setpoint_valid <= 1'b0;
			sp_x           <= '0;
			sp_y           <= '0;
			sp_z           <= '0;
			sp_yaw         <= '0;
			mode_request   <= REQ_NONE;
			current_index  <= '0;
			return_stage   <= STAGE_IDLE;
			append_ok      <= 1'b0;
		end else begin
			// Configuration writes; the radius is kept squared.
			if (cfg_valid) begin
				case (cfg_index)
					CFG_RADIUS:  radius_sq_q <= cfg_data[15:0] * cfg_data[15:0];
					CFG_RET_ALT: ret_alt_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						kind_q <= K_REPORT;
						app_q  <= 1'b0;
						state_q <= ST_FINISH;
						unique case (mode)
							MODE_APPEND: begin
								kind_q <= K_APPEND;
								if (entry_q < DEPTH_C) begin
									entry_q <= entry_q + 1'b1;
									app_q   <= 1'b1;
								end
							end
							MODE_CLEAR: begin
								entry_q  <= '0;
								active_q <= '0;
							end
							MODE_TICK: begin
								if (pos_valid) begin
									kind_q  <= K_TICK;
									state_q <= ST_READ;
									// Home is saved on the rising edge of armed.
									if (armed && !armed_before_q) begin
										home_n_q     <= pos_x;
										home_e_q     <= pos_y;
										home_d_q     <= pos_z;
										home_known_q <= 1'b1;
									end
									armed_before_q <= armed;
									if (!armed) begin
										active_q <= '0;
										stage_q  <= STAGE_IDLE;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					step_q  <= '0;
					acc_q   <= '0;
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					// The product of step n is registered in sq_s1 and added in step n+1.
					if (step_q != 2'd0) begin
						acc_q <= acc_q + {1'b0, sq_s1};
					end
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						active_q       <= active_nx;
						stage_q        <= stage_nx;
						out_valid      <= 1'b1;
						setpoint_valid <= r_spv;
						sp_x           <= r_x;
						sp_y           <= r_y;
						sp_z           <= r_z;
						sp_yaw         <= r_yaw;
						mode_request   <= r_req;
						current_index  <= idx_wide[4:0];
						return_stage   <= stage_nx;
						append_ok      <= (kind_q == K_APPEND) && app_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/mwrs_checker.sv
// Port-level checker for the waypoint sequencer, bound to the top level.
`include "mission_waypoint_rtl_sequencer_macros.svh"

module mwrs_checker
	import mwrs_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    setpoint_valid,
	input logic signed [POS_W-1:0] sp_x,
	input logic signed [POS_W-1:0] sp_y,
	input logic signed [POS_W-1:0] sp_z,
	input logic signed [YAW_W-1:0] sp_yaw,
	input logic [1:0]              mode_request,
	input logic [1:0]              return_stage,
	input logic                    append_ok
);

	// A waiting result holds until its transaction completes.
	`MWRS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sp_x) && $stable(mode_request))

	// The block works on one item at a time, so it is busy after an accept.
	`MWRS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// Without a setpoint every setpoint field reads zero.
	`MWRS_ASSERT_IMP(a_sp_zero, out_valid && !setpoint_valid, sp_x == 0 && sp_y == 0 && sp_z == 0 && sp_yaw == 0)

	// A landing request only comes from the final return stage.
	`MWRS_ASSERT_IMP(a_land_stage, out_valid && mode_request == REQ_LAND, return_stage == STAGE_LAND && !setpoint_valid)

	// A stored append carries no setpoint and no request.
	`MWRS_ASSERT_IMP(a_append_only, out_valid && append_ok, !setpoint_valid && mode_request == REQ_NONE)

endmodule

bind mission_waypoint_rtl_sequencer mwrs_checker u_mwrs_checker (.*);
